// ===== hw/rtl/alle_pkg.sv =====
// Shared types and codes for the array linked list engine.
package alle_pkg;

    // Operation codes carried in the input tuser field
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result status codes carried in the output tuser field
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS1,
        ST_INS2,
        ST_INS3,
        ST_RM1,
        ST_RM2,
        ST_RM3,
        ST_LOC,
        ST_RESP
    } state_t;

endpackage

// ===== hw/rtl/alle_ram.sv =====
// Generic simple dual port RAM, one write port and one registered read port.
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/array_linked_list_engine.sv =====
// Top level of the array linked list engine: sequencer over the link and value stores.
//
// Doubly linked list held in a slot store. Slot 0 is the sentinel: its next link is
// the head, its prev link the tail. Free slots are chained through their next links.
// Input channel s_*: s_tuser is the operation (insert after slot, remove slot, locate
// by position), s_tdata carries value, slot and position. Output channel m_*: one
// result per input transfer, m_tuser is the status, m_tdata carries the new or found
// slot, the removed value and the element count after the operation.
// Locate follows the smaller of the list length and position - 1 links, and none
// for position 0. Every dependent link read goes through the single read port of
// the link RAM. One item is in work at a time.
// The output register holds a finished result; the next item is accepted while it
// waits. If the receiver stalls, a second result waits in its last state with no
// side effects until the output register frees up.
// After reset a clearing pass writes every entry of the link RAM, during which
// s_tready stays low.
module array_linked_list_engine #(
    parameter int SLOT_COUNT  = 255,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], slot[39:32], position[47:40]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot_out[7:0], value_out[39:8], count_out[47:40]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import alle_pkg::*;

    localparam int LW     = $clog2(SLOT_COUNT + 1);
    localparam int DEPTH  = SLOT_COUNT + 1;
    localparam int LINK_D = 2 * LW + 1;
    localparam int VW     = VALUE_WIDTH;

    // Input fields
    op_t         in_op;
    logic [31:0] in_value;
    logic [7:0]  in_slot;
    logic [7:0]  in_pos;

    assign in_op    = op_t'(s_tuser);
    assign in_value = s_tdata[31:0];
    assign in_slot  = s_tdata[39:32];
    assign in_pos   = s_tdata[47:40];

    // Width adaption of the input fields
    logic [LW+7:0]  in_slot_ext;
    logic [LW-1:0]  in_slot_idx;
    logic [16:0]    in_slot_wide;
    logic           in_slot_big;
    logic [VW+31:0] in_value_ext;
    logic [VW-1:0]  in_value_w;

    assign in_slot_ext  = {{LW{1'b0}}, in_slot};
    assign in_slot_idx  = in_slot_ext[LW-1:0];
    assign in_slot_wide = {9'b0, in_slot};
    assign in_slot_big  = in_slot_wide > 17'(SLOT_COUNT);
    assign in_value_ext = {{VW{1'b0}}, in_value};
    assign in_value_w   = in_value_ext[VW-1:0];

    // Link entry: {used, prev, next}
    function automatic logic [LINK_D-1:0] mk_link(input logic used,
                                                  input logic [LW-1:0] prv,
                                                  input logic [LW-1:0] nxt);
        return {used, prv, nxt};
    endfunction

    // Memory ports
    logic              lk_we;
    logic [LW-1:0]     lk_waddr;
    logic [LINK_D-1:0] lk_wdata;
    logic              lk_re;
    logic [LW-1:0]     lk_raddr;
    logic [LINK_D-1:0] lk_rdata;
    logic              vr_we;
    logic [LW-1:0]     vr_waddr;
    logic [VW-1:0]     vr_wdata;
    logic              vr_re;
    logic [LW-1:0]     vr_raddr;
    logic [VW-1:0]     vr_rdata;

    logic [LW-1:0] rd_next;
    logic [LW-1:0] rd_prev;
    logic          rd_used;

    assign rd_next = lk_rdata[LW-1:0];
    assign rd_prev = lk_rdata[2*LW-1:LW];
    assign rd_used = lk_rdata[2*LW];

    alle_ram #(
        .WIDTH (LINK_D),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    alle_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .re    (vr_re),
        .raddr (vr_raddr),
        .rdata (vr_rdata)
    );

    // Control and work registers
    state_t        state_reg, state_next;
    logic [LW-1:0] clr_reg, clr_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] cur_reg, cur_next;       // slot of the item
    logic          bad_reg, bad_next;       // slot field above SLOT_COUNT
    logic [7:0]    pos_reg, pos_next;
    logic [7:0]    step_reg, step_next;
    logic [VW-1:0] val_reg, val_next;
    logic [LW-1:0] a_reg, a_next;           // insert: successor, remove: next
    logic [LW-1:0] b_reg, b_next;           // insert: new slot, remove: prev
    logic [VW-1:0] res_value_reg, res_value_next;
    status_t       res_status_reg, res_status_next;

    // Output register
    logic          m_tvalid_reg;
    status_t       m_status_reg;
    logic [7:0]    m_slot_reg;
    logic [31:0]   m_value_reg;
    logic [7:0]    m_count_reg;

    logic          can_load;
    logic          load_out;
    status_t       ld_status;
    logic [LW-1:0] ld_slot;
    logic [VW-1:0] ld_value;

    assign can_load = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: next state, memory accesses and result load
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        bad_next        = bad_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        val_next        = val_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        lk_we           = 1'b0;
        lk_waddr        = '0;
        lk_wdata        = '0;
        lk_re           = 1'b0;
        lk_raddr        = '0;
        vr_we           = 1'b0;
        vr_waddr        = '0;
        vr_wdata        = '0;
        vr_re           = 1'b0;
        vr_raddr        = '0;
        load_out        = 1'b0;
        ld_status       = STATUS_OK;
        ld_slot         = '0;
        ld_value        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                if (clr_reg == '0 || clr_reg == LW'(SLOT_COUNT))
                begin
                    lk_wdata = mk_link(1'b0, '0, '0);
                end
                else
                begin
                    lk_wdata = mk_link(1'b0, '0, clr_reg + 1'b1);
                end
                if (clr_reg == LW'(SLOT_COUNT))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_next  = in_slot_idx;
                    bad_next  = in_slot_big;
                    pos_next  = in_pos;
                    val_next  = in_value_w;
                    step_next = 8'd1;
                    case (in_op)
                        OP_INSERT:
                        begin
                            lk_re      = 1'b1;
                            lk_raddr   = in_slot_idx;
                            state_next = ST_INS1;
                        end
                        OP_REMOVE:
                        begin
                            lk_re      = 1'b1;
                            lk_raddr   = in_slot_idx;
                            vr_re      = 1'b1;
                            vr_raddr   = in_slot_idx;
                            state_next = ST_RM1;
                        end
                        OP_LOCATE:
                        begin
                            lk_re      = 1'b1;
                            lk_raddr   = '0;
                            state_next = ST_LOC;
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                            state_next      = ST_RESP;
                        end
                    endcase
                end
            end

            // Predecessor entry is read: check it, link it to the new slot
            ST_INS1:
            begin
                if (bad_reg || (cur_reg != '0 && !rd_used))
                begin
                    res_status_next = STATUS_BAD;
                    state_next      = ST_RESP;
                end
                else if (free_head_reg == '0)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = ST_RESP;
                end
                else
                begin
                    a_next     = rd_next;
                    b_next     = free_head_reg;
                    lk_we      = 1'b1;
                    lk_waddr   = cur_reg;
                    lk_wdata   = mk_link(rd_used, rd_prev, free_head_reg);
                    lk_re      = 1'b1;
                    lk_raddr   = free_head_reg;
                    state_next = ST_INS2;
                end
            end

            // New slot entry is read: pop the free chain, fill the slot
            ST_INS2:
            begin
                free_head_next = rd_next;
                lk_we          = 1'b1;
                lk_waddr       = b_reg;
                lk_wdata       = mk_link(1'b1, cur_reg, a_reg);
                vr_we          = 1'b1;
                vr_waddr       = b_reg;
                vr_wdata       = val_reg;
                lk_re          = 1'b1;
                lk_raddr       = a_reg;
                state_next     = ST_INS3;
            end

            // Successor entry is read (already updated when it is the predecessor)
            ST_INS3:
            begin
                if (can_load)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = a_reg;
                    lk_wdata   = mk_link(rd_used, b_reg, rd_next);
                    count_next = count_reg + 1'b1;
                    load_out   = 1'b1;
                    ld_status  = STATUS_OK;
                    ld_slot    = b_reg;
                    state_next = ST_IDLE;
                end
            end

            // Removed entry is read: check it, push it on the free chain
            ST_RM1:
            begin
                if (bad_reg || cur_reg == '0 || !rd_used)
                begin
                    res_status_next = STATUS_BAD;
                    state_next      = ST_RESP;
                end
                else
                begin
                    a_next         = rd_next;
                    b_next         = rd_prev;
                    res_value_next = vr_rdata;
                    free_head_next = cur_reg;
                    lk_we          = 1'b1;
                    lk_waddr       = cur_reg;
                    lk_wdata       = mk_link(1'b0, '0, free_head_reg);
                    lk_re          = 1'b1;
                    lk_raddr       = rd_next;
                    state_next     = ST_RM2;
                end
            end

            // Next neighbor is read: point its prev link back
            ST_RM2:
            begin
                lk_we      = 1'b1;
                lk_waddr   = a_reg;
                lk_wdata   = mk_link(rd_used, b_reg, rd_next);
                lk_re      = 1'b1;
                lk_raddr   = b_reg;
                state_next = ST_RM3;
            end

            // Prev neighbor is read; when it is also the next neighbor (both the
            // sentinel) the read raced last cycle's write, so its prev link is forwarded
            ST_RM3:
            begin
                if (can_load)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = b_reg;
                    lk_wdata   = mk_link(rd_used, (a_reg == b_reg) ? b_reg : rd_prev, a_reg);
                    count_next = count_reg - 1'b1;
                    load_out   = 1'b1;
                    ld_status  = STATUS_OK;
                    ld_value   = res_value_reg;
                    state_next = ST_IDLE;
                end
            end

            // Walk: rd_next is the slot at position step_reg
            ST_LOC:
            begin
                if (step_reg >= pos_reg || rd_next == '0)
                begin
                    if (can_load)
                    begin
                        load_out   = 1'b1;
                        ld_status  = STATUS_OK;
                        ld_slot    = rd_next;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    lk_re     = 1'b1;
                    lk_raddr  = rd_next;
                    step_next = step_reg + 8'd1;
                end
            end

            // Result with no change to the list
            ST_RESP:
            begin
                if (can_load)
                begin
                    load_out   = 1'b1;
                    ld_status  = res_status_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= LW'(1);
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Work registers of the item in progress
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        bad_reg        <= bad_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        val_reg        <= val_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    // Output payload, sized to the port fields
    logic [LW+7:0]  ld_slot_ext;
    logic [LW+7:0]  ld_count_ext;
    logic [VW+31:0] ld_value_ext;

    assign ld_slot_ext  = {8'b0, ld_slot};
    assign ld_count_ext = {8'b0, count_next};
    assign ld_value_ext = {32'b0, ld_value};

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_status_reg <= ld_status;
            m_slot_reg   <= ld_slot_ext[7:0];
            m_value_reg  <= ld_value_ext[31:0];
            m_count_reg  <= ld_count_ext[7:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_count_reg, m_value_reg, m_slot_reg};

`ifndef SYNTHESIS
    // Between items the free chain is empty exactly when the store is full
    a_free_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((free_head_reg == '0) == (count_reg == LW'(SLOT_COUNT))))
        else $error("free head and element count disagree");

    // The element count never exceeds the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LW'(SLOT_COUNT))
        else $error("element count above slot count");

    // The sentinel is never marked in use
    a_sentinel_free: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_we && lk_waddr == '0) |-> !lk_wdata[2*LW])
        else $error("sentinel written as in use");

    // A result is loaded only when the output register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !load_out)
        else $error("pending result overwritten");
`endif

endmodule
